>>> hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/css_pkg.sv
package css_pkg;

    // Default deepest nesting level of slash-plus comments.
    localparam int MAX_NEST_DEFAULT = 255;

    // Character codes that the scanner reacts to.
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    // Scan phase, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_OPEN  = 5'b00010,
        PH_LINE  = 5'b00100,
        PH_BLOCK = 5'b01000,
        PH_NEST  = 5'b10000
    } phase_t;

    // Byte held from the previous item that may start a two-byte sequence.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CLOSE = 2'd1,
        PEND_SLASH = 2'd2
    } pend_t;

    // Status reported with each result item.
    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_PENDING      = 3'd1,
        ST_INSIDE       = 3'd2,
        ST_ENDS         = 3'd3,
        ST_ENDED_BEFORE = 3'd4,
        ST_REJECT       = 3'd5
    } status_t;

    // Comment kinds.
    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_BLOCK = 2'd1,
        KIND_NEST  = 2'd2
    } kind_t;

    // Scanner state apart from the nest depth, whose width is a parameter.
    typedef struct packed {
        phase_t phase;
        kind_t  kind;
        logic   backslash_odd;
        logic   after_cr;
        pend_t  pend;
    } scan_state_t;

    // One result item.
    typedef struct packed {
        status_t status;
        logic    in_comment;
        kind_t   kind;
    } scan_result_t;

endpackage

>>> hdl/css_step.sv
module css_step #(
    parameter int MAX_NEST = css_pkg::MAX_NEST_DEFAULT,
    localparam int NestW = $clog2(MAX_NEST + 1)
) (
    input  css_pkg::scan_state_t  state_cur,
    input  logic [NestW-1:0]      nest_cur,
    input  logic                  nest_enable,
    input  logic [7:0]            data_byte,
    input  logic                  token_start,
    input  logic                  last_byte,
    output css_pkg::scan_state_t  state_nxt,
    output logic [NestW-1:0]      nest_nxt,
    output css_pkg::scan_result_t result
);

    // Return to idle; the comment kind is kept.
    function automatic css_pkg::scan_state_t idle_state(css_pkg::scan_state_t s);
        css_pkg::scan_state_t r;
        r               = s;
        r.phase         = css_pkg::PH_IDLE;
        r.backslash_odd = 1'b0;
        r.after_cr      = 1'b0;
        r.pend          = css_pkg::PEND_NONE;
        return r;
    endfunction

    // State transition and result for one byte.
    always_comb begin
        logic ended;
        ended     = 1'b0;
        state_nxt = state_cur;
        nest_nxt  = nest_cur;
        result    = '{css_pkg::ST_IDLE, 1'b0, css_pkg::KIND_LINE};
        case (state_cur.phase)
            css_pkg::PH_OPEN: begin
                state_nxt = idle_state(state_cur);
                nest_nxt  = '0;
                if (data_byte == css_pkg::CH_SLASH) begin
                    state_nxt.kind = css_pkg::KIND_LINE;
                    if (last_byte) begin
                        result = '{css_pkg::ST_ENDS, 1'b1, css_pkg::KIND_LINE};
                    end else begin
                        state_nxt.phase = css_pkg::PH_LINE;
                        result = '{css_pkg::ST_INSIDE, 1'b1, css_pkg::KIND_LINE};
                    end
                end else if (data_byte == css_pkg::CH_STAR && !last_byte) begin
                    state_nxt.kind  = css_pkg::KIND_BLOCK;
                    state_nxt.phase = css_pkg::PH_BLOCK;
                    result = '{css_pkg::ST_INSIDE, 1'b1, css_pkg::KIND_BLOCK};
                end else if (data_byte == css_pkg::CH_PLUS && nest_enable && !last_byte) begin
                    state_nxt.kind  = css_pkg::KIND_NEST;
                    state_nxt.phase = css_pkg::PH_NEST;
                    nest_nxt        = NestW'(1);
                    result = '{css_pkg::ST_INSIDE, 1'b1, css_pkg::KIND_NEST};
                end else begin
                    result = '{css_pkg::ST_REJECT, 1'b0, css_pkg::KIND_LINE};
                end
            end
            css_pkg::PH_LINE: begin
                state_nxt.after_cr = 1'b0;
                if (state_cur.after_cr && data_byte == css_pkg::CH_LF) begin
                    // The LF of a continued CR LF pair is absorbed.
                end else if (data_byte == css_pkg::CH_CR || data_byte == css_pkg::CH_LF) begin
                    if (!state_cur.backslash_odd) begin
                        ended     = 1'b1;
                        state_nxt = idle_state(state_cur);
                        nest_nxt  = '0;
                        result    = '{css_pkg::ST_ENDED_BEFORE, 1'b0, state_cur.kind};
                    end else begin
                        state_nxt.backslash_odd = 1'b0;
                        state_nxt.after_cr      = (data_byte == css_pkg::CH_CR);
                    end
                end else if (data_byte == css_pkg::CH_BACKSLASH) begin
                    state_nxt.backslash_odd = !state_cur.backslash_odd;
                end else begin
                    state_nxt.backslash_odd = 1'b0;
                end
                if (!ended) begin
                    if (last_byte) begin
                        state_nxt = idle_state(state_cur);
                        nest_nxt  = '0;
                        result    = '{css_pkg::ST_ENDS, 1'b1, state_cur.kind};
                    end else begin
                        result = '{css_pkg::ST_INSIDE, 1'b1, state_cur.kind};
                    end
                end
            end
            css_pkg::PH_BLOCK: begin
                if ((state_cur.pend == css_pkg::PEND_CLOSE && data_byte == css_pkg::CH_SLASH)
                        || last_byte) begin
                    state_nxt = idle_state(state_cur);
                    nest_nxt  = '0;
                    result    = '{css_pkg::ST_ENDS, 1'b1, state_cur.kind};
                end else begin
                    state_nxt.pend = (data_byte == css_pkg::CH_STAR) ?
                                     css_pkg::PEND_CLOSE : css_pkg::PEND_NONE;
                    result = '{css_pkg::ST_INSIDE, 1'b1, state_cur.kind};
                end
            end
            css_pkg::PH_NEST: begin
                if (state_cur.pend == css_pkg::PEND_CLOSE && data_byte == css_pkg::CH_SLASH) begin
                    state_nxt.pend = css_pkg::PEND_NONE;
                    if (nest_cur != '0) begin
                        nest_nxt = nest_cur - NestW'(1);
                    end
                    // Leaving the outermost level closes the comment.
                    if (nest_cur == NestW'(1) || nest_cur == '0) begin
                        ended = 1'b1;
                    end
                end else if (state_cur.pend == css_pkg::PEND_SLASH
                        && data_byte == css_pkg::CH_PLUS) begin
                    state_nxt.pend = css_pkg::PEND_NONE;
                    if (nest_cur < NestW'(MAX_NEST)) begin
                        nest_nxt = nest_cur + NestW'(1);
                    end
                end else if (data_byte == css_pkg::CH_PLUS) begin
                    state_nxt.pend = css_pkg::PEND_CLOSE;
                end else if (data_byte == css_pkg::CH_SLASH) begin
                    state_nxt.pend = css_pkg::PEND_SLASH;
                end else begin
                    state_nxt.pend = css_pkg::PEND_NONE;
                end
                if (ended || last_byte) begin
                    state_nxt = idle_state(state_cur);
                    nest_nxt  = '0;
                    result    = '{css_pkg::ST_ENDS, 1'b1, state_cur.kind};
                end else begin
                    result = '{css_pkg::ST_INSIDE, 1'b1, state_cur.kind};
                end
            end
            default: begin
                state_nxt = idle_state(state_cur);
                nest_nxt  = '0;
                if (!token_start) begin
                    result = '{css_pkg::ST_IDLE, 1'b0, css_pkg::KIND_LINE};
                end else if (data_byte == css_pkg::CH_SLASH && !last_byte) begin
                    state_nxt.phase = css_pkg::PH_OPEN;
                    result = '{css_pkg::ST_PENDING, 1'b1, css_pkg::KIND_LINE};
                end else begin
                    result = '{css_pkg::ST_REJECT, 1'b0, css_pkg::KIND_LINE};
                end
            end
        endcase
    end

endmodule

>>> hdl/comment_span_scanner.sv
// Comment span scanner: takes one source byte per item and, starting at a byte the caller
// marks as a token start, reports whether a C/C++ line comment, block comment or (when
// enabled through the configuration write) D nestable comment begins there, and follows
// it to its end, giving one result item per input item. An accepted item waits in an input
// register until the output register is free or being emptied; then the scan state is
// updated and its result is loaded into the output register, from which it is offered. One
// item is taken every cycle as long as results are taken; the scan state and nest counter
// are updated combinationally from each item, which sets that rate. Configuration writes
// are taken at any time and should be made while no item is in flight.
module comment_span_scanner #(
    parameter int MAX_NEST = css_pkg::MAX_NEST_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_token_start,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_scan_status,
    output logic       m_byte_in_comment,
    output logic [1:0] m_comment_kind
);

    localparam int NestW = $clog2(MAX_NEST + 1);

    logic                  enable_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_start_reg;
    logic                  in_last_reg;
    css_pkg::scan_state_t  state_reg, state_next;
    logic [NestW-1:0]      nest_reg, nest_next;
    logic                  out_valid_reg;
    css_pkg::scan_result_t out_reg, out_next;
    logic                  advance;

    // An item moves to the output when the output register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            enable_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_token_start;
            in_last_reg  <= s_last_byte;
        end
    end

    // Scan state update for the byte in the input register.
    css_step #(
        .MAX_NEST (MAX_NEST)
    ) u_step (
        .state_cur   (state_reg),
        .nest_cur    (nest_reg),
        .nest_enable (enable_reg),
        .data_byte   (in_byte_reg),
        .token_start (in_start_reg),
        .last_byte   (in_last_reg),
        .state_nxt   (state_next),
        .nest_nxt    (nest_next),
        .result      (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{css_pkg::PH_IDLE, css_pkg::KIND_LINE, 1'b0, 1'b0, css_pkg::PEND_NONE};
            nest_reg  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            nest_reg  <= nest_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_scan_status     = out_reg.status;
    assign m_byte_in_comment = out_reg.in_comment;
    assign m_comment_kind    = out_reg.kind;

endmodule

>>> hdl/css_checker.sv
`include "assert_macros.svh"

module css_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_scan_status,
    input logic       m_byte_in_comment,
    input logic [1:0] m_comment_kind
);

    logic [5:0] out_item;
    logic       body_status;
    logic       kindless_out;

    // Whole result item, and the status groups the checks below depend on.
    assign out_item     = {m_scan_status, m_byte_in_comment, m_comment_kind};
    assign body_status  = m_scan_status inside
                          {css_pkg::ST_PENDING, css_pkg::ST_INSIDE, css_pkg::ST_ENDS};
    assign kindless_out = m_valid && (m_scan_status inside
                          {css_pkg::ST_IDLE, css_pkg::ST_PENDING, css_pkg::ST_REJECT});

    // A result stays put while it waits to be taken.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_item))

    // The byte belongs to the comment exactly for pending, inside and ending results.
    `ASSERT_IMPLY(a_in_comment, aclk, aresetn, m_valid, m_byte_in_comment == body_status)

    // No kind is reported with idle, pending or reject results.
    `ASSERT_IMPLY(a_kind_zero, aclk, aresetn, kindless_out, m_comment_kind == css_pkg::KIND_LINE)

    // Reset leaves no result behind.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind comment_span_scanner css_checker u_css_checker (.*);
